>>> rtl/core/assert_macros.svh
// Assertion macros shared by the envelope evaluator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ESE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ESE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ese_pkg.sv
// Shared types, constants and lookup tables of the envelope shape evaluator.
// Depends on nothing; used by every module of the block but ese_ram.
package ese_pkg;

   localparam int MAX_POINTS = 8;
   localparam int FRAC_BITS  = 15;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int BP_W       = 34;
   localparam int STEP_W     = $clog2(FRAC_BITS);

   localparam logic [16:0] ONE = 17'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      MODE_LINEAR  = 3'd0,
      MODE_AD      = 3'd1,
      MODE_ADSR    = 3'd2,
      MODE_FADE_IN = 3'd3,
      MODE_FADE_OUT= 3'd4,
      MODE_LOG_IN  = 3'd5,
      MODE_LOG_OUT = 3'd6,
      MODE_CUSTOM  = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE    = 3'd0,
      REG_ATTACK  = 3'd1,
      REG_DECAY   = 3'd2,
      REG_SUSTAIN = 3'd3,
      REG_RELEASE = 3'd4,
      REG_FADE    = 3'd5,
      REG_COUNT   = 3'd6
   } reg_index_type;

   localparam logic       OP_EVAL       = 1'b0;
   localparam logic       OP_WRITE      = 1'b1;
   localparam logic [1:0] CURVE_LINEAR  = 2'd0;
   localparam logic [1:0] CURVE_COSINE  = 2'd1;

   typedef enum logic [3:0] {
      KIND_DIRECT   = 4'd0,
      KIND_Q        = 4'd1,
      KIND_ONE_MINUS= 4'd2,
      KIND_DECAY    = 4'd3,
      KIND_RELEASE  = 4'd4,
      KIND_BLEND    = 4'd5,
      KIND_COSINE   = 4'd6,
      KIND_LOG_IN   = 4'd7,
      KIND_LOG_OUT  = 4'd8
   } kind_type;

   typedef struct packed {
      logic capture;
      logic bp_write;
      logic scan;
      logic premul;
      logic setup;
      logic div_step;
      logic lut_mul;
      logic lut_fin;
      logic bl_a;
      logic bl_b;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

   function automatic logic [15:0] log_tab(input logic [5:0] i);
      logic [15:0] v;
      case (i)
         6'd0:  v = 16'd0;     6'd1:  v = 16'd3527;  6'd2:  v = 16'd6351;
         6'd3:  v = 16'd8707;  6'd4:  v = 16'd10727; 6'd5:  v = 16'd12496;
         6'd6:  v = 16'd14069; 6'd7:  v = 16'd15485; 6'd8:  v = 16'd16773;
         6'd9:  v = 16'd17954; 6'd10: v = 16'd19045; 6'd11: v = 16'd20058;
         6'd12: v = 16'd21004; 6'd13: v = 16'd21890; 6'd14: v = 16'd22725;
         6'd15: v = 16'd23513; 6'd16: v = 16'd24260; 6'd17: v = 16'd24970;
         6'd18: v = 16'd25646; 6'd19: v = 16'd26291; 6'd20: v = 16'd26909;
         6'd21: v = 16'd27500; 6'd22: v = 16'd28068; 6'd23: v = 16'd28615;
         6'd24: v = 16'd29141; 6'd25: v = 16'd29648; 6'd26: v = 16'd30138;
         6'd27: v = 16'd30611; 6'd28: v = 16'd31070; 6'd29: v = 16'd31514;
         6'd30: v = 16'd31944; 6'd31: v = 16'd32362;
         default: v = 16'd32768;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] cos_tab(input logic [5:0] i);
      logic [15:0] v;
      case (i)
         6'd0:  v = 16'd0;     6'd1:  v = 16'd79;    6'd2:  v = 16'd315;
         6'd3:  v = 16'd705;   6'd4:  v = 16'd1247;  6'd5:  v = 16'd1935;
         6'd6:  v = 16'd2761;  6'd7:  v = 16'd3719;  6'd8:  v = 16'd4799;
         6'd9:  v = 16'd5990;  6'd10: v = 16'd7282;  6'd11: v = 16'd8661;
         6'd12: v = 16'd10114; 6'd13: v = 16'd11628; 6'd14: v = 16'd13188;
         6'd15: v = 16'd14778; 6'd16: v = 16'd16384; 6'd17: v = 16'd17990;
         6'd18: v = 16'd19580; 6'd19: v = 16'd21140; 6'd20: v = 16'd22654;
         6'd21: v = 16'd24107; 6'd22: v = 16'd25486; 6'd23: v = 16'd26778;
         6'd24: v = 16'd27969; 6'd25: v = 16'd29049; 6'd26: v = 16'd30007;
         6'd27: v = 16'd30833; 6'd28: v = 16'd31521; 6'd29: v = 16'd32063;
         6'd30: v = 16'd32453; 6'd31: v = 16'd32689;
         default: v = 16'd32768;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/core/ese_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ese_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/ese_ctrl.sv
// Sequencer of the envelope evaluator: handshakes and the command stream.
// Depends on ese_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ese_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ese_pkg::status_type status,
   output ese_pkg::cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_SCAN  = 10'b0000000010,
      ST_PRE   = 10'b0000000100,
      ST_SETUP = 10'b0000001000,
      ST_DIV   = 10'b0000010000,
      ST_LUTM  = 10'b0000100000,
      ST_LUTF  = 10'b0001000000,
      ST_BLA   = 10'b0010000000,
      ST_BLB   = 10'b0100000000,
      ST_FIN   = 10'b1000000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [ese_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == ese_pkg::OP_WRITE) begin
                  cmd.bp_write = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            cmd.premul = 1'b1;
            state_in   = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            step_in   = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == ese_pkg::STEP_W'(ese_pkg::FRAC_BITS - 1)) begin
               state_in = ST_LUTM;
            end
         end
         ST_LUTM: begin
            cmd.lut_mul = 1'b1;
            state_in    = ST_LUTF;
         end
         ST_LUTF: begin
            cmd.lut_fin = 1'b1;
            state_in    = ST_BLA;
         end
         ST_BLA: begin
            cmd.bl_a = 1'b1;
            state_in = ST_BLB;
         end
         ST_BLB: begin
            cmd.bl_b = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // The result register may only be reloaded once the last one is gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ESE_ASSERT(a_eval_starts_scan, clock, reset,
      (accept && req_operation == ese_pkg::OP_EVAL) |=> (state_ff == ST_SCAN),
      "evaluate transaction did not start the breakpoint scan")

   `ESE_ASSERT(a_lut_after_div, clock, reset,
      (state_ff == ST_LUTM) |-> ($past(state_ff) == ST_DIV),
      "table stage entered without a finished division")

   `ESE_ASSERT(a_rsp_from_fin, clock, reset,
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN),
      "result raised outside the final stage")

endmodule

>>> rtl/core/ese_datapath.sv
// Datapath of the envelope evaluator: registers, breakpoint scan, divider,
// shared multiplier and table interpolation. Depends on ese_pkg and ese_ram.
module ese_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ese_pkg::cmd_type    cmd,
   output ese_pkg::status_type status,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic [15:0]         req_time_point,
   input  logic [2:0]          req_point_index,
   input  logic [15:0]         req_point_time,
   input  logic [15:0]         req_point_value,
   input  logic [1:0]          req_point_curve,
   output logic [15:0]         rsp_level
);

   localparam int CW = ese_pkg::CNT_W;

   // Configuration registers
   ese_pkg::mode_type mode_ff;
   logic [15:0] attack_ff, decay_ff, sustain_ff, release_ff, fade_ff;
   logic [3:0]  count_ff;

   logic [15:0] t_ff;
   logic [CW-1:0] n_eff;
   logic          custom;

   // Scan state
   logic [CW-1:0] iss_ff;
   logic          rvld_ff, rfirst_ff, found_ff;
   logic [15:0]   first_t_ff, first_v_ff, prev_t_ff, prev_v_ff, last_t_ff, last_v_ff;
   logic [1:0]    prev_c_ff;
   logic [15:0]   seg_t1_ff, seg_t2_ff, seg_v1_ff, seg_v2_ff;
   logic [1:0]    seg_c_ff;
   logic [ese_pkg::BP_W-1:0] rdata;
   logic [15:0]   e_time, e_value;
   logic [1:0]    e_curve;

   // Setup, divider and arithmetic
   ese_pkg::kind_type kind_ff, su_kind;
   logic [16:0] direct_ff, su_direct;
   logic        su_div;
   logic [17:0] su_num, su_den;
   logic [16:0] su_preset;
   logic [17:0] rem_ff, den_ff;
   logic [16:0] q_ff;
   logic        run_ff;
   logic [18:0] rem2;
   logic [16:0] ad_sum;
   logic [17:0] adr_sum, ads_sum;
   logic [15:0] sus;
   logic [17:0] scaled;
   logic [16:0] tf_sum;
   logic [16:0] sl;

   logic [33:0] prod_a_ff, prod_b_ff, mul_p;
   logic [16:0] mul_x, mul_y;
   logic [5:0]  lut_idx;
   logic [ese_pkg::FRAC_BITS-1:0] lut_fr;
   logic [15:0] lut_lo, lut_hi;
   logic [16:0] lp_ff, pb;
   logic [34:0] fin_wide;
   logic [15:0] level_ff;

   ese_ram #(.WIDTH(ese_pkg::BP_W), .DEPTH(ese_pkg::MAX_POINTS)) u_bp_ram (
      .clock (clock),
      .we    (cmd.bp_write),
      .waddr (req_point_index[ese_pkg::IDX_W-1:0]),
      .wdata ({req_point_curve, req_point_value, req_point_time}),
      .raddr (iss_ff[ese_pkg::IDX_W-1:0]),
      .rdata (rdata)
   );

   assign e_time  = rdata[15:0];
   assign e_value = rdata[31:16];
   assign e_curve = rdata[33:32];

   assign custom = (mode_ff == ese_pkg::MODE_CUSTOM);
   assign n_eff  = (32'(count_ff) > ese_pkg::MAX_POINTS) ? CW'(ese_pkg::MAX_POINTS)
                                                          : CW'(count_ff);
   assign status.scan_done = !custom || ((iss_ff == n_eff) && !rvld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= ese_pkg::MODE_LINEAR;
         attack_ff  <= '0;
         decay_ff   <= '0;
         sustain_ff <= '0;
         release_ff <= '0;
         fade_ff    <= '0;
         count_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ese_pkg::REG_MODE:    mode_ff    <= ese_pkg::mode_type'(csr_wdata[2:0]);
            ese_pkg::REG_ATTACK:  attack_ff  <= csr_wdata;
            ese_pkg::REG_DECAY:   decay_ff   <= csr_wdata;
            ese_pkg::REG_SUSTAIN: sustain_ff <= csr_wdata;
            ese_pkg::REG_RELEASE: release_ff <= csr_wdata;
            ese_pkg::REG_FADE:    fade_ff    <= csr_wdata;
            ese_pkg::REG_COUNT:   count_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Breakpoint scan: one entry issued per cycle, processed in the following cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff   <= '0;
         rvld_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else if (cmd.capture) begin
         iss_ff   <= '0;
         rvld_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else if (cmd.scan) begin
         rvld_ff <= custom && (iss_ff < n_eff);
         if (custom && (iss_ff < n_eff)) begin
            iss_ff <= iss_ff + 1'b1;
         end
         if (rvld_ff && !rfirst_ff && !found_ff && (prev_t_ff <= t_ff) && (t_ff <= e_time)) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         t_ff <= req_time_point;
      end
      if (cmd.scan) begin
         rfirst_ff <= (iss_ff == '0);
         if (rvld_ff) begin
            prev_t_ff <= e_time;
            prev_v_ff <= e_value;
            prev_c_ff <= e_curve;
            last_t_ff <= e_time;
            last_v_ff <= e_value;
            if (rfirst_ff) begin
               first_t_ff <= e_time;
               first_v_ff <= e_value;
            end else if (!found_ff && (prev_t_ff <= t_ff) && (t_ff <= e_time)) begin
               seg_t1_ff <= prev_t_ff;
               seg_t2_ff <= e_time;
               seg_v1_ff <= prev_v_ff;
               seg_v2_ff <= e_value;
               seg_c_ff  <= prev_c_ff;
            end
         end
      end
   end

   // Branch selection for the current mode.
   assign ad_sum  = {1'b0, attack_ff} + {1'b0, decay_ff};
   assign adr_sum = {1'b0, ad_sum} + {2'b0, release_ff};
   assign sus     = (adr_sum >= 18'(ese_pkg::ONE)) ? 16'd0 : 16'(18'(ese_pkg::ONE) - adr_sum);
   assign ads_sum = {1'b0, ad_sum} + {2'b0, sus};
   assign scaled  = prod_a_ff[ese_pkg::FRAC_BITS+17:ese_pkg::FRAC_BITS];
   assign tf_sum  = {1'b0, t_ff} + {1'b0, fade_ff};
   assign sl      = ({1'b0, sustain_ff} > ese_pkg::ONE) ? ese_pkg::ONE : {1'b0, sustain_ff};

   always_comb begin
      su_kind   = ese_pkg::KIND_DIRECT;
      su_direct = '0;
      su_div    = 1'b0;
      su_num    = '0;
      su_den    = '0;
      su_preset = '0;
      unique case (mode_ff)
         ese_pkg::MODE_LINEAR: begin
            su_direct = {1'b0, t_ff};
         end
         ese_pkg::MODE_AD: begin
            if (ad_sum != '0) begin
               su_div = 1'b1;
               if (scaled < {2'b0, attack_ff}) begin
                  su_kind = ese_pkg::KIND_Q;
                  su_num  = scaled;
                  su_den  = {2'b0, attack_ff};
               end else begin
                  su_kind = ese_pkg::KIND_ONE_MINUS;
                  su_num  = scaled - {2'b0, attack_ff};
                  su_den  = {2'b0, decay_ff};
               end
            end
         end
         ese_pkg::MODE_ADSR: begin
            if (t_ff < attack_ff) begin
               su_div  = 1'b1;
               su_kind = ese_pkg::KIND_Q;
               su_num  = {2'b0, t_ff};
               su_den  = {2'b0, attack_ff};
            end else if ({1'b0, t_ff} < ad_sum) begin
               su_div  = 1'b1;
               su_kind = ese_pkg::KIND_DECAY;
               su_num  = {2'b0, t_ff - attack_ff};
               su_den  = {2'b0, decay_ff};
            end else if ({2'b0, t_ff} < ads_sum) begin
               su_direct = sl;
            end else begin
               su_div  = 1'b1;
               su_kind = ese_pkg::KIND_RELEASE;
               su_num  = {2'b0, t_ff} - ads_sum;
               su_den  = {2'b0, release_ff};
            end
         end
         ese_pkg::MODE_FADE_IN: begin
            if (t_ff < fade_ff) begin
               su_div  = 1'b1;
               su_kind = ese_pkg::KIND_Q;
               su_num  = {2'b0, t_ff};
               su_den  = {2'b0, fade_ff};
            end else begin
               su_direct = ese_pkg::ONE;
            end
         end
         ese_pkg::MODE_FADE_OUT: begin
            if (tf_sum < ese_pkg::ONE) begin
               su_direct = ese_pkg::ONE;
            end else begin
               su_div  = 1'b1;
               su_kind = ese_pkg::KIND_ONE_MINUS;
               su_num  = {1'b0, tf_sum - ese_pkg::ONE};
               su_den  = {2'b0, fade_ff};
            end
         end
         ese_pkg::MODE_LOG_IN, ese_pkg::MODE_LOG_OUT: begin
            su_kind   = (mode_ff == ese_pkg::MODE_LOG_IN) ? ese_pkg::KIND_LOG_IN
                                                          : ese_pkg::KIND_LOG_OUT;
            su_preset = ({1'b0, t_ff} > ese_pkg::ONE) ? ese_pkg::ONE : {1'b0, t_ff};
         end
         ese_pkg::MODE_CUSTOM: begin
            if (n_eff == '0) begin
               su_direct = '0;
            end else if ((n_eff == CW'(1)) || (t_ff <= first_t_ff)) begin
               su_direct = {1'b0, first_v_ff};
            end else if (t_ff >= last_t_ff) begin
               su_direct = {1'b0, last_v_ff};
            end else if (found_ff) begin
               if (seg_c_ff == ese_pkg::CURVE_LINEAR || seg_c_ff == ese_pkg::CURVE_COSINE) begin
                  su_div  = 1'b1;
                  su_kind = (seg_c_ff == ese_pkg::CURVE_COSINE) ? ese_pkg::KIND_COSINE
                                                                : ese_pkg::KIND_BLEND;
                  su_num  = {2'b0, t_ff - seg_t1_ff};
                  su_den  = {2'b0, seg_t2_ff - seg_t1_ff};
               end else begin
                  su_direct = {1'b0, seg_v1_ff};
               end
            end
         end
         default: ;
      endcase
   end

   // Restoring divider, one quotient bit a cycle. Quotients at or above one
   // are settled at setup, so only the fraction bits are iterated.
   assign rem2 = {rem_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (cmd.setup) begin
         run_ff <= su_div && (su_den != '0) && (su_num < su_den);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         kind_ff   <= su_kind;
         direct_ff <= su_direct;
         rem_ff    <= su_num;
         den_ff    <= su_den;
         if (!su_div) begin
            q_ff <= su_preset;
         end else if (su_den == '0) begin
            q_ff <= '0;
         end else if (su_num >= su_den) begin
            q_ff <= ese_pkg::ONE;
         end else begin
            q_ff <= '0;
         end
      end else if (cmd.div_step && run_ff) begin
         if (rem2 >= {1'b0, den_ff}) begin
            rem_ff <= 18'(rem2 - {1'b0, den_ff});
            q_ff   <= {q_ff[15:0], 1'b1};
         end else begin
            rem_ff <= rem2[17:0];
            q_ff   <= {q_ff[15:0], 1'b0};
         end
      end
   end

   // Table interpolation on the quotient
   assign lut_idx = q_ff[ese_pkg::FRAC_BITS:ese_pkg::FRAC_BITS-5];
   assign lut_fr  = {q_ff[ese_pkg::FRAC_BITS-6:0], 5'b0};

   always_comb begin
      if (kind_ff == ese_pkg::KIND_COSINE) begin
         lut_lo = ese_pkg::cos_tab(lut_idx);
         lut_hi = (lut_idx >= 6'd32) ? lut_lo : ese_pkg::cos_tab(lut_idx + 6'd1);
      end else begin
         lut_lo = ese_pkg::log_tab(lut_idx);
         lut_hi = (lut_idx >= 6'd32) ? lut_lo : ese_pkg::log_tab(lut_idx + 6'd1);
      end
   end

   assign pb = (kind_ff == ese_pkg::KIND_COSINE) ? lp_ff : q_ff;

   // Shared multiplier operand selection
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      if (cmd.premul) begin
         mul_x = {1'b0, t_ff};
         mul_y = ad_sum;
      end else if (cmd.lut_mul) begin
         mul_x = {1'b0, lut_hi - lut_lo};
         mul_y = 17'(lut_fr);
      end else if (cmd.bl_a) begin
         case (kind_ff)
            ese_pkg::KIND_BLEND, ese_pkg::KIND_COSINE: begin
               mul_x = {1'b0, seg_v1_ff};
               mul_y = ese_pkg::ONE - pb;
            end
            ese_pkg::KIND_DECAY: begin
               mul_x = q_ff;
               mul_y = ese_pkg::ONE - sl;
            end
            ese_pkg::KIND_RELEASE: begin
               mul_x = sl;
               mul_y = ese_pkg::ONE - q_ff;
            end
            default: ;
         endcase
      end else if (cmd.bl_b) begin
         if (kind_ff == ese_pkg::KIND_BLEND || kind_ff == ese_pkg::KIND_COSINE) begin
            mul_x = {1'b0, seg_v2_ff};
            mul_y = pb;
         end
      end
   end

   assign mul_p = 34'(mul_x) * 34'(mul_y);

   always_ff @(posedge clock) begin
      if (cmd.premul || cmd.lut_mul || cmd.bl_a) begin
         prod_a_ff <= mul_p;
      end
      if (cmd.bl_b) begin
         prod_b_ff <= mul_p;
      end
      if (cmd.lut_fin) begin
         lp_ff <= {1'b0, lut_lo} + 17'(prod_a_ff >> ese_pkg::FRAC_BITS);
      end
   end

   always_comb begin
      case (kind_ff)
         ese_pkg::KIND_DIRECT:    fin_wide = 35'(direct_ff);
         ese_pkg::KIND_Q:         fin_wide = 35'(q_ff);
         ese_pkg::KIND_ONE_MINUS: fin_wide = 35'(ese_pkg::ONE - q_ff);
         ese_pkg::KIND_DECAY:     fin_wide = 35'(ese_pkg::ONE)
                                             - 35'(prod_a_ff >> ese_pkg::FRAC_BITS);
         ese_pkg::KIND_RELEASE:   fin_wide = 35'(prod_a_ff >> ese_pkg::FRAC_BITS);
         ese_pkg::KIND_BLEND, ese_pkg::KIND_COSINE:
                                  fin_wide = (35'(prod_a_ff) + 35'(prod_b_ff))
                                             >> ese_pkg::FRAC_BITS;
         ese_pkg::KIND_LOG_IN:    fin_wide = 35'(lp_ff);
         ese_pkg::KIND_LOG_OUT:   fin_wide = (lp_ff > ese_pkg::ONE) ? 35'd0
                                             : 35'(ese_pkg::ONE - lp_ff);
         default:                 fin_wide = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         level_ff <= (fin_wide > 35'(ese_pkg::ONE)) ? 16'(ese_pkg::ONE) : fin_wide[15:0];
      end
   end

   assign rsp_level = level_ff;

endmodule

>>> rtl/core/envelope_shape_evaluator.sv
// Top level of the envelope shape evaluator.
// Depends on ese_pkg, ese_ctrl and ese_datapath.
//
// Usage:
// The req channel carries one transaction per item. An evaluate transaction
// (operation 0) returns one level on the rsp channel; a breakpoint write
// (operation 1) stores point_time, point_value and point_curve into slot
// point_index and returns nothing.
// The csr port writes the mode and timing registers with csr_we, csr_index
// and csr_wdata; the user must see that it is written only while the block
// is idle, as the block itself does not enforce this.
// In custom mode the breakpoint scan reads one RAM entry a cycle; then a
// restoring divider produces the fraction bits and a shared multiplier does
// the scaling, table and blend steps. One evaluate is in flight at a time
// and the next transaction is accepted in the same cycle as the result
// appears.
// The result sits in an output register: the next transaction is accepted
// while it waits, but a new result is only written once rsp_ready took it.
// Reset clears the registers to zero and the mode to linear; breakpoint
// slots hold no defined value until they are written.
module envelope_shape_evaluator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [15:0] req_time_point,
   input  logic [2:0]  req_point_index,
   input  logic [15:0] req_point_time,
   input  logic [15:0] req_point_value,
   input  logic [1:0]  req_point_curve,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_level,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ese_pkg::cmd_type    cmd;
   ese_pkg::status_type status;

   ese_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   ese_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_time_point  (req_time_point),
      .req_point_index (req_point_index),
      .req_point_time  (req_point_time),
      .req_point_value (req_point_value),
      .req_point_curve (req_point_curve),
      .rsp_level       (rsp_level)
   );

endmodule
